// ===== hw/rtl/rgb_box_blur_top_defines.svh =====
// Assertion macros used by the rgb_box_blur RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef RGB_BOX_BLUR_TOP_DEFINES_SVH
`define RGB_BOX_BLUR_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RBB_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rgb_box_blur: same-cycle check failed");

// next-cycle implication, disabled in reset
`define RBB_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rgb_box_blur: next-cycle check failed");

`endif

// ===== hw/rtl/rbb_pkg.sv =====
// Shared types and fixed constants for the rgb_box_blur block.
// No dependencies; used by the controller, datapath and top level.
package rbb_pkg;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int RADIUS_W  = 4;
    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int CH_MAX    = 255;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [RADIUS_W-1:0] RADIUS_RST = 4'd1;
    localparam logic [CFG_W-1:0]    WIDTH_RST  = 11'd640;
    localparam logic [CFG_W-1:0]    HEIGHT_RST = 11'd480;

    typedef struct packed {
        logic step;
        logic win_start;
        logic win_next;
        logic div_start;
        logic div_next;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic due;
        logic win_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

// ===== hw/rtl/rbb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/rbb_ctrl.sv =====
// Sequencer for rgb_box_blur: accepts requests, walks the window, runs the divider.
// Depends on rbb_pkg and rgb_box_blur_top_defines.svh.
`include "rgb_box_blur_top_defines.svh"

module rbb_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output rbb_pkg::cmd_t cmd,
    input  rbb_pkg::sts_t sts
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
    localparam logic [ST_W-1:0] ST_WIN  = 3'd1;
    localparam logic [ST_W-1:0] ST_ACC  = 3'd2;
    localparam logic [ST_W-1:0] ST_LOAD = 3'd3;
    localparam logic [ST_W-1:0] ST_DIV  = 3'd4;
    localparam logic [ST_W-1:0] ST_HOLD = 3'd5;

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;
    logic            accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.step = 1'b1;
                    if (sts.due) begin
                        cmd.win_start = 1'b1;
                        state_next    = ST_WIN;
                    end
                end
            end
            ST_WIN: begin
                cmd.win_next = 1'b1;
                if (sts.win_last) begin
                    state_next = ST_ACC;
                end
            end
            // last window read lands here
            ST_ACC: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_next = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `RBB_ASSERT_NEXT(a_due_starts_window, aclk, aresetn, accept && sts.due, state_reg == ST_WIN)
    `RBB_ASSERT_NEXT(a_acc_then_load, aclk, aresetn, state_reg == ST_ACC, state_reg == ST_LOAD)
    `RBB_ASSERT_NEXT(a_hold_waits, aclk, aresetn, (state_reg == ST_HOLD) && !sts.out_free, state_reg == ST_HOLD)
    `RBB_ASSERT_NOW(a_load_only_when_free, aclk, aresetn, cmd.out_load, sts.out_free)

endmodule

// ===== hw/rtl/rbb_datapath.sv =====
// Datapath for rgb_box_blur: config registers, position counters, row store,
// window accumulators, bit-serial dividers and the output register.
// Depends on rbb_pkg and rbb_ram.
module rbb_datapath #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbb_pkg::CFG_W-1:0]      cfg_data,
    input  logic [rbb_pkg::PIX_W-1:0]      s_tdata,
    input  logic [0:0]                     s_tuser,
    output logic [rbb_pkg::PIX_W-1:0]      m_tdata,
    output logic                           m_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    input  rbb_pkg::cmd_t                  cmd,
    output rbb_pkg::sts_t                  sts
);

    localparam int RING    = 2 * MAX_RADIUS + 2;
    localparam int RING_W  = $clog2(RING);
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int DIM_W   = $clog2(MAX_WIDTH + 1);
    localparam int HDIM_W  = $clog2(MAX_HEIGHT + 1);
    localparam int R_W     = $clog2(MAX_RADIUS + 1);
    localparam int WIN_W   = $clog2(2 * MAX_RADIUS + 1);
    localparam int LAT_MAX = MAX_RADIUS * MAX_WIDTH + MAX_RADIUS;
    localparam int P_W     = $clog2(LAT_MAX + 2);
    localparam int N_MAX   = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
    localparam int N_W     = $clog2(N_MAX + 1);
    localparam int SUM_W   = $clog2(N_MAX * rbb_pkg::CH_MAX + 1);
    localparam int NUM_W   = SUM_W + 1;
    localparam int DEN_W   = N_W + 1;
    localparam int DC_W    = $clog2(NUM_W);
    localparam int DEPTH   = RING * MAX_WIDTH;
    localparam int A_W     = $clog2(DEPTH);
    localparam int RS_W    = HDIM_W + WIN_W + 1;
    localparam int CS_W    = DIM_W + WIN_W + 1;
    localparam int EXT_W   = 13;
    localparam int CH_W    = rbb_pkg::CH_W;

    // configuration
    logic [rbb_pkg::RADIUS_W-1:0] radius_reg;
    logic [rbb_pkg::CFG_W-1:0]    fwidth_reg;
    logic [rbb_pkg::CFG_W-1:0]    fheight_reg;
    logic [R_W-1:0]    r_eff;
    logic [DIM_W-1:0]  w_eff;
    logic [HDIM_W-1:0] h_eff;
    logic [P_W-1:0]    lat;
    logic [N_W-1:0]    n_win;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg  <= rbb_pkg::RADIUS_RST;
            fwidth_reg  <= rbb_pkg::WIDTH_RST;
            fheight_reg <= rbb_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                rbb_pkg::REG_RADIUS: radius_reg  <= cfg_data[rbb_pkg::RADIUS_W-1:0];
                rbb_pkg::REG_WIDTH:  fwidth_reg  <= cfg_data;
                rbb_pkg::REG_HEIGHT: fheight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (EXT_W'(radius_reg) > EXT_W'(MAX_RADIUS)) begin
            r_eff = R_W'(MAX_RADIUS);
        end else begin
            r_eff = R_W'(radius_reg);
        end
        if (fwidth_reg == '0) begin
            w_eff = DIM_W'(1);
        end else if (EXT_W'(fwidth_reg) > EXT_W'(MAX_WIDTH)) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = DIM_W'(fwidth_reg);
        end
        if (fheight_reg == '0) begin
            h_eff = HDIM_W'(1);
        end else if (EXT_W'(fheight_reg) > EXT_W'(MAX_HEIGHT)) begin
            h_eff = HDIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = HDIM_W'(fheight_reg);
        end
    end

    assign lat   = P_W'(r_eff) * P_W'(w_eff) + P_W'(r_eff);
    assign n_win = N_W'((2 * r_eff + 1) * (2 * r_eff + 1));

    // position counters
    logic [COL_W-1:0]  in_col_reg;
    logic [HDIM_W-1:0] in_row_reg;
    logic [RING_W-1:0] in_ring_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [HDIM_W-1:0] out_row_reg;
    logic [RING_W-1:0] out_ring_reg;
    logic [P_W-1:0]    pend_reg;
    logic              in_frame;
    logic              pix_write;
    logic              counts;
    logic              out_last;

    assign in_frame  = in_row_reg < h_eff;
    assign pix_write = cmd.step && in_frame && !s_tuser[0];
    assign counts    = !(in_frame && s_tuser[0]);
    assign out_last  = (DIM_W'(out_col_reg) + 1'b1 == w_eff) && (out_row_reg + 1'b1 == h_eff);

    assign sts.due = counts && (pend_reg + 1'b1 > lat) && (out_row_reg < h_eff);

    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_we || (cmd.out_load && out_last)) begin
            in_col_reg   <= '0;
            in_row_reg   <= '0;
            in_ring_reg  <= '0;
            out_col_reg  <= '0;
            out_row_reg  <= '0;
            out_ring_reg <= '0;
            pend_reg     <= '0;
        end else begin
            if (cmd.step && counts) begin
                pend_reg <= pend_reg + 1'b1;
            end
            if (cmd.out_load) begin
                pend_reg <= pend_reg - 1'b1;
                if (DIM_W'(out_col_reg) + 1'b1 == w_eff) begin
                    out_col_reg  <= '0;
                    out_row_reg  <= out_row_reg + 1'b1;
                    out_ring_reg <= (out_ring_reg == RING_W'(RING - 1)) ? '0
                                                                         : out_ring_reg + 1'b1;
                end else begin
                    out_col_reg <= out_col_reg + 1'b1;
                end
            end
            if (pix_write) begin
                if (DIM_W'(in_col_reg) + 1'b1 == w_eff) begin
                    in_col_reg  <= '0;
                    in_row_reg  <= in_row_reg + 1'b1;
                    in_ring_reg <= (in_ring_reg == RING_W'(RING - 1)) ? '0 : in_ring_reg + 1'b1;
                end else begin
                    in_col_reg <= in_col_reg + 1'b1;
                end
            end
        end
    end

    // window walk
    logic [WIN_W-1:0]  win_x_reg;
    logic [WIN_W-1:0]  win_y_reg;
    logic [RING_W-1:0] rd_ring_reg;
    logic [RING_W-1:0] start_ring;
    logic [RS_W-1:0]   row_u;
    logic [CS_W-1:0]   col_u;
    logic              pix_ok;
    logic              x_end;
    logic              rd_vld_reg;
    logic [A_W-1:0]    raddr;
    logic [A_W-1:0]    waddr;
    logic [rbb_pkg::PIX_W-1:0] rdata;

    assign start_ring = (RING_W'(out_ring_reg) >= RING_W'(r_eff))
                        ? out_ring_reg - RING_W'(r_eff)
                        : RING_W'(out_ring_reg + RING_W'(RING) - RING_W'(r_eff));
    assign row_u  = RS_W'(out_row_reg) + RS_W'(win_y_reg) - RS_W'(r_eff);
    assign col_u  = CS_W'(out_col_reg) + CS_W'(win_x_reg) - CS_W'(r_eff);
    assign pix_ok = !row_u[RS_W-1] && (row_u < RS_W'(h_eff))
                 && !col_u[CS_W-1] && (col_u < CS_W'(w_eff));
    assign x_end  = (win_x_reg == WIN_W'(2 * r_eff));
    assign sts.win_last = x_end && (win_y_reg == WIN_W'(2 * r_eff));

    assign raddr = A_W'(rd_ring_reg * MAX_WIDTH) + A_W'(col_u[COL_W-1:0]);
    assign waddr = A_W'(in_ring_reg * MAX_WIDTH) + A_W'(in_col_reg);

    always_ff @(posedge aclk) begin
        if (cmd.win_start) begin
            win_x_reg   <= '0;
            win_y_reg   <= '0;
            rd_ring_reg <= start_ring;
        end else if (cmd.win_next) begin
            if (x_end) begin
                win_x_reg   <= '0;
                win_y_reg   <= win_y_reg + 1'b1;
                rd_ring_reg <= (rd_ring_reg == RING_W'(RING - 1)) ? '0 : rd_ring_reg + 1'b1;
            end else begin
                win_x_reg <= win_x_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg <= cmd.win_next && pix_ok;
        end
    end

    rbb_ram #(
        .WIDTH (rbb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_row_store (
        .aclk  (aclk),
        .we    (pix_write),
        .waddr (waddr),
        .wdata (s_tdata),
        .re    (cmd.win_next && pix_ok),
        .raddr (raddr),
        .rdata (rdata)
    );

    // per-channel sums and restoring dividers; channel 0 is red
    logic [SUM_W-1:0] acc_reg [3];
    logic [NUM_W-1:0] num_reg [3];
    logic [DEN_W-1:0] rem_reg [3];
    logic [DEN_W:0]   rem_sh  [3];
    logic             q_bit   [3];
    logic [DC_W-1:0]  div_cnt_reg;
    logic [DEN_W-1:0] den;

    assign den = {n_win, 1'b0};
    assign sts.div_last = (div_cnt_reg == DC_W'(NUM_W - 1));

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            rem_sh[c] = {rem_reg[c], num_reg[c][NUM_W-1]};
            q_bit[c]  = rem_sh[c] >= {1'b0, den};
        end
    end

    always_ff @(posedge aclk) begin
        for (int c = 0; c < 3; c++) begin
            if (cmd.win_start) begin
                acc_reg[c] <= '0;
            end else if (rd_vld_reg) begin
                acc_reg[c] <= acc_reg[c] + SUM_W'(rdata[c*CH_W +: CH_W]);
            end
            if (cmd.div_start) begin
                num_reg[c] <= {acc_reg[c], 1'b0} + NUM_W'(n_win);
                rem_reg[c] <= '0;
            end else if (cmd.div_next) begin
                num_reg[c] <= {num_reg[c][NUM_W-2:0], q_bit[c]};
                rem_reg[c] <= q_bit[c] ? DEN_W'(rem_sh[c] - {1'b0, den}) : DEN_W'(rem_sh[c]);
            end
        end
        if (cmd.div_start) begin
            div_cnt_reg <= '0;
        end else if (cmd.div_next) begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // output register
    logic                      m_valid_reg;
    logic [rbb_pkg::PIX_W-1:0] m_data_reg;
    logic                      m_last_reg;

    assign sts.out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            for (int c = 0; c < 3; c++) begin
                m_data_reg[c*CH_W +: CH_W] <= (num_reg[c] > NUM_W'(rbb_pkg::CH_MAX))
                                              ? CH_W'(rbb_pkg::CH_MAX)
                                              : num_reg[c][CH_W-1:0];
            end
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ===== hw/rtl/rgb_box_blur_top.sv =====
// Zero-padded box blur of an RGB raster stream: each output pixel is the rounded,
// clamped per-channel mean of its (2R+1)x(2R+1) window, pixels outside the frame
// counting as zero. Output k leaves once R*W+R+k+1 requests are in; after the
// frame's last pixel send R*W+R flush requests (tuser = 1) to drain it. A request
// that yields a result fetches one window pixel per cycle through the row store's
// single read port, then a restoring divider produces one quotient bit per cycle
// over NUM_W = clog2((2*MAX_RADIUS+1)^2*255+1)+1 numerator bits (18 at defaults).
// A finished result sits in the output register while the next request is taken.
// The row store needs no clearing pass. Any config write restarts the frame.
// Depends on rbb_pkg, rbb_ctrl, rbb_datapath and rbb_ram.
module rgb_box_blur_top #(
    parameter int MAX_RADIUS = 8,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [rbb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rbb_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rbb_pkg::PIX_W-1:0]     s_tdata,  // in_red, in_green, in_blue
    input  logic [0:0]                    s_tuser,  // mode
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rbb_pkg::PIX_W-1:0]     m_tdata,  // out_red, out_green, out_blue
    output logic                          m_tlast
);

    rbb_pkg::cmd_t cmd;
    rbb_pkg::sts_t sts;

    rbb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    rbb_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
